>>> src/bounded_circular_list_engine_unit_defines.svh
// Assertion macros for the circular list engine.
`ifndef BOUNDED_CIRCULAR_LIST_ENGINE_UNIT_DEFINES_SVH
`define BOUNDED_CIRCULAR_LIST_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define BCLE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define BCLE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BCLE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define BCLE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> src/bcle_pkg.sv
// Shared constants, codes and controller/datapath interface types.
`default_nettype none
package bcle_pkg;

   localparam int CAPACITY     = 32;
   localparam int IDX_W        = $clog2(CAPACITY);
   localparam int CNT_W        = $clog2(CAPACITY + 1);
   localparam int VALUE_W      = 32;
   localparam int POS_W        = 8;
   localparam int FUNC_W       = 3;
   localparam int STATUS_W     = 2;
   localparam int ITEM_COUNT_W = 6;
   localparam int CMP_W        = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int REQ_DATA_W   = ((VALUE_W + POS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((VALUE_W + ITEM_COUNT_W + 7) / 8) * 8;

   typedef enum logic [FUNC_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_END   = 3'd1,
      OP_INS_POS   = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_END   = 3'd4,
      OP_DEL_POS   = 3'd5,
      OP_LIST      = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SHIFT,
      S_RESPOND,
      S_LIST_PRIME,
      S_LIST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic decide;
      logic shift;
      logic respond;
      logic list_prime;
      logic list_emit;
   } cmd_type;

   typedef struct packed {
      logic go_shift;
      logic go_list;
      logic shift_done;
      logic out_free;
      logic list_last;
   } stat_type;

endpackage
`default_nettype wire

>>> src/bcle_datapath.sv
// Entry memory, count, shift walker and result register.
`default_nettype none
module bcle_datapath (
   input  wire                               clock,
   input  wire                               reset,
   input  bcle_pkg::cmd_type                 cmd,
   output bcle_pkg::stat_type                stat,
   // value, position
   input  wire  [bcle_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func
   input  wire  [bcle_pkg::FUNC_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // item_value, item_count, zero pad
   output logic [bcle_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic [bcle_pkg::STATUS_W-1:0]     rsp_tuser,
   output logic                              rsp_tlast
);
   import bcle_pkg::*;

   logic [VALUE_W-1:0] mem [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [VALUE_W-1:0] wr_data;

   op_type                    op_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [POS_W-1:0]          pos_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   status_type       status_ff, status_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0] src_ff, src_in;
   logic [IDX_W-1:0] dst_ff, dst_in;
   logic             pend_ff, pend_in;
   logic             ins_ff, ins_in;
   logic             del_ff, del_in;
   logic [IDX_W-1:0] list_idx_ff, list_idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic             full, empty, out_free, rsp_load, list_last;
   logic [CMP_W-1:0] cnt_ext, pos_ext;
   status_type       dec_st;
   logic [CNT_W-1:0] dec_idx;
   logic             dec_ins, dec_del;

   assign full      = count_ff >= CNT_W'(CAPACITY);
   assign empty     = count_ff == '0;
   assign cnt_ext   = CMP_W'(count_ff);
   assign pos_ext   = CMP_W'(pos_ff);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign list_last = (CNT_W'(list_idx_ff) + CNT_W'(1)) == count_ff;

   // status and target index of the latched request
   always_comb begin
      dec_st  = ST_OK;
      dec_idx = '0;
      dec_ins = 1'b0;
      dec_del = 1'b0;
      unique case (op_ff)
         OP_INS_FRONT: begin
            if (full) dec_st = ST_FULL;
            else dec_ins = 1'b1;
         end
         OP_INS_END: begin
            dec_idx = count_ff;
            if (full) dec_st = ST_FULL;
            else dec_ins = 1'b1;
         end
         OP_INS_POS: begin
            dec_idx = CNT_W'(pos_ext - CMP_W'(1));
            if (pos_ff == '0) dec_st = ST_BADPOS;
            else if (full) dec_st = ST_FULL;
            else if (pos_ext > cnt_ext + CMP_W'(1)) dec_st = ST_BADPOS;
            else dec_ins = 1'b1;
         end
         OP_DEL_FRONT: begin
            if (empty) dec_st = ST_EMPTY;
            else dec_del = 1'b1;
         end
         OP_DEL_END: begin
            dec_idx = count_ff - CNT_W'(1);
            if (empty) dec_st = ST_EMPTY;
            else dec_del = 1'b1;
         end
         OP_DEL_POS: begin
            dec_idx = CNT_W'(pos_ext - CMP_W'(1));
            if (pos_ff == '0) dec_st = ST_BADPOS;
            else if (empty) dec_st = ST_EMPTY;
            else if (pos_ext > cnt_ext) dec_st = ST_BADPOS;
            else dec_del = 1'b1;
         end
         OP_LIST: begin
            if (empty) dec_st = ST_EMPTY;
         end
         default: dec_st = ST_BADPOS;
      endcase
   end

   always_comb begin
      status_in   = status_ff;
      idx_in      = idx_ff;
      rem_in      = rem_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      pend_in     = pend_ff;
      ins_in      = ins_ff;
      del_in      = del_ff;
      list_idx_in = list_idx_ff;
      count_in    = count_ff;
      rd_addr     = src_ff;
      wr_en       = 1'b0;
      wr_addr     = dst_ff;
      wr_data     = rd_data_ff;
      rsp_load    = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.decide) begin
         status_in   = dec_st;
         idx_in      = IDX_W'(dec_idx);
         ins_in      = dec_ins;
         del_in      = dec_del;
         pend_in     = 1'b0;
         list_idx_in = '0;
         if (dec_ins) begin
            // walk down from the tail, moving each entry up one
            rem_in = count_ff - dec_idx;
            src_in = IDX_W'(count_ff - CNT_W'(1));
         end else begin
            // walk up from the gap, moving each entry down one
            rem_in = count_ff - CNT_W'(1) - dec_idx;
            src_in = IDX_W'(dec_idx + CNT_W'(1));
         end
      end

      if (cmd.shift) begin
         wr_en = pend_ff;
         if (rem_ff != '0) begin
            rd_addr = src_ff;
            pend_in = 1'b1;
            rem_in  = rem_ff - CNT_W'(1);
            if (ins_ff) begin
               dst_in = src_ff + IDX_W'(1);
               src_in = src_ff - IDX_W'(1);
            end else begin
               dst_in = src_ff - IDX_W'(1);
               src_in = src_ff + IDX_W'(1);
            end
         end else begin
            pend_in = 1'b0;
         end
      end

      if (cmd.respond && out_free) begin
         rsp_load = 1'b1;
         if (ins_ff) begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = value_ff;
            count_in = count_ff + CNT_W'(1);
         end else if (del_ff) begin
            count_in = count_ff - CNT_W'(1);
         end
         rsp_status_in = status_ff;
         rsp_value_in  = '0;
         rsp_count_in  = count_in;
         rsp_last_in   = 1'b1;
      end

      if (cmd.list_prime) begin
         rd_addr = list_idx_ff;
      end

      if (cmd.list_emit) begin
         rd_addr = list_idx_ff;
         if (out_free) begin
            // hand out the fetched entry and fetch the next one
            rsp_load      = 1'b1;
            rsp_status_in = ST_OK;
            rsp_value_in  = rd_data_ff;
            rsp_count_in  = count_ff;
            rsp_last_in   = list_last;
            list_idx_in   = list_idx_ff + IDX_W'(1);
            rd_addr       = list_idx_in;
         end
      end

      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= op_type'(req_tuser);
         value_ff <= req_tdata[VALUE_W-1:0];
         pos_ff   <= req_tdata[VALUE_W +: POS_W];
      end
      status_ff     <= status_in;
      idx_ff        <= idx_in;
      rem_ff        <= rem_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      pend_ff       <= pend_in;
      ins_ff        <= ins_in;
      del_ff        <= del_in;
      list_idx_ff   <= list_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign stat.go_shift   = dec_ins || dec_del;
   assign stat.go_list    = (op_ff == OP_LIST) && !empty;
   assign stat.shift_done = (rem_ff == '0) && !pend_ff;
   assign stat.out_free   = out_free;
   assign stat.list_last  = list_last;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({ITEM_COUNT_W'(rsp_count_ff), rsp_value_ff});
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

>>> src/bcle_controller.sv
// Sequencer that steps each request through decode, then shift and response, response alone, or list prime and emit.
`default_nettype none
module bcle_controller (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  bcle_pkg::stat_type  stat,
   output bcle_pkg::cmd_type   cmd
);
   import bcle_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:       if (req_tvalid) state_in = S_DECIDE;
         S_DECIDE: begin
            priority if (stat.go_shift) state_in = S_SHIFT;
            else if (stat.go_list) state_in = S_LIST_PRIME;
            else state_in = S_RESPOND;
         end
         S_SHIFT:      if (stat.shift_done) state_in = S_RESPOND;
         S_RESPOND:    if (stat.out_free) state_in = S_IDLE;
         S_LIST_PRIME: state_in = S_LIST_EMIT;
         S_LIST_EMIT:  if (stat.out_free && stat.list_last) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      req_tready     = (state_ff == S_IDLE);
      cmd.accept     = (state_ff == S_IDLE) && req_tvalid;
      cmd.decide     = (state_ff == S_DECIDE);
      cmd.shift      = (state_ff == S_SHIFT);
      cmd.respond    = (state_ff == S_RESPOND);
      cmd.list_prime = (state_ff == S_LIST_PRIME);
      cmd.list_emit  = (state_ff == S_LIST_EMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule
`default_nettype wire

>>> src/bounded_circular_list_engine_unit.sv
// Sequence: an insert or delete goes through decide, shift and respond, also when nothing
// moves; a rejected request goes from decide to respond, a list through prime and emit.
// Throughput: one request at a time; a list gives one beat a cycle while the output is free.
// A finished beat waits in the output register while the next request is taken.
// Reset clears the count, the sequencer and the output valid; entries are not cleared.
`default_nettype none
`include "bounded_circular_list_engine_unit_defines.svh"
module bounded_circular_list_engine_unit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // value, position
   input  wire  [bcle_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func
   input  wire  [bcle_pkg::FUNC_W-1:0]        req_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // item_value, item_count, zero pad
   output logic [bcle_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status
   output logic [bcle_pkg::STATUS_W-1:0]      rsp_tuser,
   output logic                               rsp_tlast
);
   import bcle_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bcle_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bcle_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `BCLE_ASSERT_NXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while busy")
   `BCLE_ASSERT_IMP(a_empty_count, clock, reset, rsp_tvalid && (rsp_tuser == ST_EMPTY), rsp_tdata[VALUE_W +: ITEM_COUNT_W] == '0, "empty status with entries")
   `BCLE_ASSERT_IMP(a_full_count, clock, reset, rsp_tvalid && (rsp_tuser == ST_FULL), rsp_tdata[VALUE_W +: ITEM_COUNT_W] == ITEM_COUNT_W'(CAPACITY), "full status below capacity")
   `BCLE_ASSERT_IMP(a_list_ok, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tuser == ST_OK, "non-final beat without ok status")

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the circular list engine: directed table, then random ops.
`timescale 1ns / 1ps
module tb_top;
   import bcle_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_SPARE = 3'd7;
   localparam int DIRECTED_ROWS = 21;
   localparam int RANDOM_ITEMS  = 350;
   localparam int SEG_LEN       = 50;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int TAIL_CYCLES   = CAPACITY + 10;

   typedef struct packed {
      status_type         status;
      logic [31:0]        value;
      logic [5:0]         count;
      logic               last;
   } beat_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [31:0]        value;
      logic [7:0]         pos;
      logic               typed;
      status_type         status;
      logic [5:0]         count;
   } dir_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic [FUNC_W-1:0]       req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [STATUS_W-1:0]     rsp_tuser;
   logic                    rsp_tlast;

   // shadow copy of the list contents
   logic [31:0]             list_vals [CAPACITY];
   int                      list_len;
   beat_type                pending_beats [$];
   int                      mismatch_count;
   int                      cycle_count;
   dir_row_type             dir_rows [DIRECTED_ROWS];

   bounded_circular_list_engine_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // value, position
      .req_tuser  (req_tuser),   // func
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // item_value, item_count, zero pad
      .rsp_tuser  (rsp_tuser),   // status
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic status_type put_entry(input int idx, input logic [31:0] v);
      if (list_len >= CAPACITY) return ST_FULL;
      for (int i = list_len; i > idx; i--) list_vals[i] = list_vals[i-1];
      list_vals[idx] = v;
      list_len++;
      return ST_OK;
   endfunction

   function automatic status_type take_entry(input int idx);
      if (list_len == 0) return ST_EMPTY;
      for (int i = idx; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
      list_len--;
      return ST_OK;
   endfunction

   // Apply one op to the shadow list and append the beats it should produce.
   function automatic void predict_list_op(input logic [FUNC_W-1:0] f, input logic [31:0] v,
                                           input logic [7:0] p, ref beat_type beats [$]);
      status_type st;
      st = ST_OK;
      case (f)
         OP_INS_FRONT: st = put_entry(0, v);
         OP_INS_END:   st = put_entry(list_len, v);
         OP_INS_POS: begin
            if (p == 0) st = ST_BADPOS;
            else if (list_len >= CAPACITY) st = ST_FULL;
            else if (int'(p) > list_len + 1) st = ST_BADPOS;
            else st = put_entry(int'(p) - 1, v);
         end
         OP_DEL_FRONT: st = take_entry(0);
         OP_DEL_END:   st = (list_len == 0) ? ST_EMPTY : take_entry(list_len - 1);
         OP_DEL_POS: begin
            if (p == 0) st = ST_BADPOS;
            else if (list_len == 0) st = ST_EMPTY;
            else if (int'(p) > list_len) st = ST_BADPOS;
            else st = take_entry(int'(p) - 1);
         end
         OP_LIST: begin
            if (list_len == 0) begin
               beats.push_back('{ST_EMPTY, 32'd0, 6'd0, 1'b1});
            end else begin
               for (int i = 0; i < list_len; i++)
                  beats.push_back('{ST_OK, list_vals[i], 6'(list_len), (i + 1 == list_len)});
            end
            return;
         end
         default: st = ST_BADPOS;
      endcase
      beats.push_back('{st, 32'd0, 6'(list_len), 1'b1});
   endfunction

   // Offer one beat and hold it until accepted; then queue its expected results.
   task automatic offer_item(input logic [FUNC_W-1:0] f, input logic [31:0] v,
                             input logic [7:0] p, input logic typed,
                             input status_type t_status, input logic [5:0] t_count);
      beat_type beats [$];
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= REQ_DATA_W'({p, v});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_list_op(f, v, p, beats);
      if (typed) begin
         beats.delete();
         beats.push_back('{t_status, 32'd0, t_count, 1'b1});
      end
      foreach (beats[i]) pending_beats.push_back(beats[i]);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] pick_pos();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 8'($urandom_range(0, list_len + 2));
      if (r < 80) return (list_len > 0) ? 8'($urandom_range(1, list_len)) : 8'd1;
      return 8'($urandom_range(0, 255));
   endfunction

   // fill segments favor inserts, drain segments favor deletes
   function automatic logic [FUNC_W-1:0] pick_func(input bit fill);
      int r;
      r = $urandom_range(0, 99);
      if (fill) begin
         if (r < 85) return 3'($urandom_range(OP_INS_FRONT, OP_INS_POS));
         if (r < 92) return 3'($urandom_range(OP_DEL_FRONT, OP_DEL_POS));
      end else begin
         if (r < 25) return 3'($urandom_range(OP_INS_FRONT, OP_INS_POS));
         if (r < 88) return 3'($urandom_range(OP_DEL_FRONT, OP_DEL_POS));
      end
      if (r < 98) return OP_LIST;
      return FUNC_SPARE;
   endfunction

   // result side: check every beat, stall at random, one long hold-off
   initial begin
      beat_type exp_b;
      int    stall_left;
      int    hold_left;
      int    seen;
      bit    held;
      bit    steady;
      int    r;
      rsp_tready     = 1'b0;
      mismatch_count = 0;
      stall_left     = 0;
      hold_left      = 0;
      seen           = 0;
      held           = 1'b0;
      steady         = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_beats.size() == 0) begin
               $error("unexpected beat: status %0d item_value %0d item_count %0d last %0b",
                      rsp_tuser, $signed(rsp_tdata[31:0]), rsp_tdata[37:32], rsp_tlast);
               mismatch_count++;
            end else begin
               exp_b = pending_beats.pop_front();
               if (rsp_tuser !== exp_b.status) begin
                  $error("status: expected %0d, got %0d", exp_b.status, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tdata[31:0] !== exp_b.value) begin
                  $error("item_value: expected %0d, got %0d",
                         $signed(exp_b.value), $signed(rsp_tdata[31:0]));
                  mismatch_count++;
               end
               if (rsp_tdata[37:32] !== exp_b.count) begin
                  $error("item_count: expected %0d, got %0d", exp_b.count, rsp_tdata[37:32]);
                  mismatch_count++;
               end
               if (rsp_tlast !== exp_b.last) begin
                  $error("last: expected %0b, got %0b", exp_b.last, rsp_tlast);
                  mismatch_count++;
               end
            end
            seen++;
            steady = ((seen / 120) % 3) == 2;
         end
         if (!held && seen >= 60) begin
            held      = 1'b1;
            hold_left = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!steady) begin
               r = $urandom_range(0, 99);
               if (r < 15) stall_left = $urandom_range(1, 3);
               else if (r < 18) stall_left = $urandom_range(10, 40);
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int               gap;
      int               seg;
      bit               fill;
      bit               no_idle;
      logic [FUNC_W-1:0] f;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      list_len   = 0;

      // func, value, position, typed, status, count
      dir_rows[0]  = '{OP_LIST,      32'd0,        8'd0,   1'b1, ST_EMPTY,  6'd0};
      dir_rows[1]  = '{OP_DEL_FRONT, 32'd0,        8'd0,   1'b1, ST_EMPTY,  6'd0};
      dir_rows[2]  = '{OP_DEL_END,   32'd0,        8'd0,   1'b1, ST_EMPTY,  6'd0};
      dir_rows[3]  = '{OP_DEL_POS,   32'd0,        8'd0,   1'b1, ST_BADPOS, 6'd0};
      dir_rows[4]  = '{OP_DEL_POS,   32'd0,        8'd1,   1'b1, ST_EMPTY,  6'd0};
      dir_rows[5]  = '{OP_INS_POS,   32'd5,        8'd0,   1'b1, ST_BADPOS, 6'd0};
      dir_rows[6]  = '{OP_INS_POS,   32'd5,        8'd2,   1'b1, ST_BADPOS, 6'd0};
      dir_rows[7]  = '{OP_INS_POS,   32'h8000_0000, 8'd1,  1'b1, ST_OK,     6'd1};
      dir_rows[8]  = '{OP_INS_FRONT, 32'h7fff_ffff, 8'd0,  1'b1, ST_OK,     6'd2};
      dir_rows[9]  = '{OP_INS_END,   32'hffff_ffff, 8'hff, 1'b1, ST_OK,     6'd3};
      dir_rows[10] = '{OP_INS_POS,   32'd0,        8'd4,   1'b1, ST_OK,     6'd4};
      dir_rows[11] = '{OP_INS_POS,   32'd1,        8'hff,  1'b1, ST_BADPOS, 6'd4};
      dir_rows[12] = '{FUNC_SPARE,   32'hffff_ffff, 8'hff, 1'b1, ST_BADPOS, 6'd4};
      dir_rows[13] = '{OP_LIST,      32'd0,        8'd0,   1'b0, ST_OK,     6'd0};
      dir_rows[14] = '{OP_INS_POS,   32'h1234_5678, 8'd2,  1'b0, ST_OK,     6'd0};
      dir_rows[15] = '{OP_DEL_POS,   32'd0,        8'd6,   1'b1, ST_BADPOS, 6'd5};
      dir_rows[16] = '{OP_DEL_POS,   32'd0,        8'd2,   1'b1, ST_OK,     6'd4};
      dir_rows[17] = '{OP_DEL_END,   32'd0,        8'd0,   1'b1, ST_OK,     6'd3};
      dir_rows[18] = '{OP_DEL_FRONT, 32'd0,        8'd0,   1'b1, ST_OK,     6'd2};
      dir_rows[19] = '{OP_DEL_POS,   32'd0,        8'hff,  1'b1, ST_BADPOS, 6'd2};
      dir_rows[20] = '{OP_LIST,      32'd0,        8'd0,   1'b0, ST_OK,     6'd0};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         offer_item(dir_rows[i].func, dir_rows[i].value, dir_rows[i].pos,
                    dir_rows[i].typed, dir_rows[i].status, dir_rows[i].count);
         gap = pick_gap();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         seg     = n / SEG_LEN;
         fill    = (seg % 2) == 0;
         no_idle = (seg % 3) == 2;
         // pause the sender until every outstanding beat is back
         if (n == RANDOM_ITEMS / 2 && pending_beats.size() != 0) begin
            req_tvalid <= 1'b0;
            while (pending_beats.size() != 0) @(posedge clock);
         end
         f = pick_func(fill);
         offer_item(f, pick_value(), pick_pos(), 1'b0, ST_OK, 6'd0);
         gap = no_idle ? 0 : pick_gap();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;

      while (pending_beats.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
